>>> hw/rtl/ptz_frame_receiver_defines.svh
// Assertion macros used by the frame receiver
`ifndef PTZ_FRAME_RECEIVER_DEFINES_SVH
`define PTZ_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
`define PTZ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ptz assertion failed");
`define PTZ_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("ptz reset assertion failed");
`else
`define PTZ_ASSERT(label, prop)
`define PTZ_ASSERT_RST(label, prop)
`endif

`endif

>>> hw/rtl/ptz_pkg.sv
package ptz_pkg;

  localparam int unsigned HoldLen = 6;

  typedef logic [7:0] byte_t;

  localparam byte_t SyncMain = 8'hFF;
  localparam byte_t SyncAlt  = 8'h53;
  localparam byte_t AddrMain = 8'h01;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    byte_t sync_byte;
    byte_t second_byte;
    byte_t third_byte;
    byte_t fourth_byte;
    byte_t fifth_byte;
    byte_t sixth_byte;
    byte_t sum_byte;
  } frame_t;

endpackage

>>> hw/rtl/ptz_if.sv
interface ptz_byte_if;
  import ptz_pkg::*;

  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ptz_frame_if;
  import ptz_pkg::*;

  logic  valid;
  logic  ready;
  byte_t sync_byte;
  byte_t second_byte;
  byte_t third_byte;
  byte_t fourth_byte;
  byte_t fifth_byte;
  byte_t sixth_byte;
  byte_t sum_byte;

  modport source (
    output valid, output sync_byte, output second_byte, output third_byte,
    output fourth_byte, output fifth_byte, output sixth_byte, output sum_byte,
    input ready
  );
  modport sink (
    input valid, input sync_byte, input second_byte, input third_byte,
    input fourth_byte, input fifth_byte, input sixth_byte, input sum_byte,
    output ready
  );
endinterface

>>> hw/rtl/ptz_cell.sv
module ptz_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptz_pkg::cell_ctrl_t ctrl_i,
  input  ptz_pkg::byte_t     byte_i,
  input  logic               valid_i,
  input  ptz_pkg::byte_t     sum_i,
  output ptz_pkg::byte_t     byte_o,
  output logic               valid_o,
  output ptz_pkg::byte_t     sum_o
);
  import ptz_pkg::*;

  byte_t byte_q;
  logic  valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign valid_o = valid_q;
  assign sum_o   = sum_i + byte_q;

endmodule

>>> hw/rtl/ptz_out_reg.sv
module ptz_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  ptz_pkg::frame_t   frame_i,
  output logic              space_o,
  ptz_frame_if.source       frame_o
);
  import ptz_pkg::*;

  logic   valid_q;
  logic   valid_d;
  frame_t frame_q;

  assign space_o = !valid_q || frame_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (frame_o.ready) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end
  end

  assign frame_o.valid       = valid_q;
  assign frame_o.sync_byte   = frame_q.sync_byte;
  assign frame_o.second_byte = frame_q.second_byte;
  assign frame_o.third_byte  = frame_q.third_byte;
  assign frame_o.fourth_byte = frame_q.fourth_byte;
  assign frame_o.fifth_byte  = frame_q.fifth_byte;
  assign frame_o.sixth_byte  = frame_q.sixth_byte;
  assign frame_o.sum_byte    = frame_q.sum_byte;

endmodule

>>> hw/rtl/ptz_frame_receiver.sv
// Accepting a closing byte registers its frame, which then shows on frame_o.
// One byte per cycle unless stalled; the six cells shift on each non-closing byte.
// rx_i stalls only while a finished frame waits in the output register.
// Reset (async, active low) empties the window and drops any pending frame.
`include "ptz_frame_receiver_defines.svh"

module ptz_frame_receiver (
  input  logic         clk_i,
  input  logic         rst_ni,
  ptz_byte_if.sink     rx_i,
  ptz_frame_if.source  frame_o
);
  import ptz_pkg::*;

  byte_t      cell_byte  [HoldLen+1];
  logic       cell_valid [HoldLen+1];
  byte_t      cell_sum   [HoldLen+1];
  cell_ctrl_t ctrl;
  logic       space;
  logic       accept;
  logic       head_ok;
  logic       frame_ok;
  logic       load;
  frame_t     frame;

  assign cell_byte[HoldLen]  = rx_i.rx_byte;
  assign cell_valid[HoldLen] = 1'b1;
  assign cell_sum[0]         = '0;

  for (genvar k = 0; k < HoldLen; k++) begin : g_cell
    ptz_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .byte_i  (cell_byte[k+1]),
      .valid_i (cell_valid[k+1]),
      .sum_i   (cell_sum[k]),
      .byte_o  (cell_byte[k]),
      .valid_o (cell_valid[k]),
      .sum_o   (cell_sum[k+1])
    );
  end

  assign rx_i.ready = space;
  assign accept     = rx_i.valid && space;

  assign head_ok  = (cell_byte[0] == SyncAlt) ||
                    ((cell_byte[0] == SyncMain) && (cell_byte[1] == AddrMain));
  assign frame_ok = cell_valid[0] && head_ok && (rx_i.rx_byte == cell_sum[HoldLen]);

  assign load       = accept && frame_ok;
  assign ctrl.clear = load;
  assign ctrl.shift = accept && !frame_ok;

  assign frame.sync_byte   = cell_byte[0];
  assign frame.second_byte = cell_byte[1];
  assign frame.third_byte  = cell_byte[2];
  assign frame.fourth_byte = cell_byte[3];
  assign frame.fifth_byte  = cell_byte[4];
  assign frame.sixth_byte  = cell_byte[5];
  assign frame.sum_byte    = rx_i.rx_byte;

  ptz_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .frame_i (frame),
    .space_o (space),
    .frame_o (frame_o)
  );

  `PTZ_ASSERT(a_rise_after_accept, $rose(frame_o.valid) |-> $past(accept))
  `PTZ_ASSERT(a_window_cleared, load |=> !cell_valid[0] && !cell_valid[HoldLen-1])
  `PTZ_ASSERT(a_frame_head, frame_o.valid |-> (frame_o.sync_byte == SyncAlt) || ((frame_o.sync_byte == SyncMain) && (frame_o.second_byte == AddrMain)))
  `PTZ_ASSERT(a_frame_sum, frame_o.valid |-> frame_o.sum_byte == byte_t'(frame_o.sync_byte + frame_o.second_byte + frame_o.third_byte + frame_o.fourth_byte + frame_o.fifth_byte + frame_o.sixth_byte))
  `PTZ_ASSERT_RST(a_reset_empty, !rst_ni |=> !frame_o.valid || !$past(rst_ni))

endmodule
